>>> design/sobel_rgb_edge_magnitude_defines.svh
// Assertion macros for the edge magnitude block.
`ifndef SOBEL_RGB_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_RGB_EDGE_MAGNITUDE_DEFINES_SVH

`ifndef SYNTHESIS

`define SRE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sre assertion failed");

`define SRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sre assertion failed");

`else

`define SRE_ASSERT_SAME(label, clk, rst, ante, cons)

`define SRE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/sre_pkg.sv
package sre_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SHIFT,
      ST_GRAD,
      ST_SQR,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      GSEL_PRE,
      GSEL_POST,
      GSEL_FINAL
   } grad_sel_type;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;

   localparam logic [7:0]  EDGE_MAX   = 8'd255;
   localparam logic [20:0] SAT_LIMIT  = 21'd65025;
   localparam logic [2:0]  SQRT_LAST  = 3'd7;
   localparam logic [14:0] SQRT_BIT0  = 15'h4000;

   typedef struct packed {
      logic         capture;
      logic         read_en;
      logic         grad_en;
      grad_sel_type grad_sel;
      logic         final_clear;
      logic         shift_en;
      logic         sqr_en;
      logic         sqrt_step;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic ignore;
      logic final_px;
      logic pre;
      logic post;
      logic sqrt_last;
      logic out_busy;
   } status_type;

endpackage

>>> design/sobel_rgb_edge_magnitude.sv
// Sobel 3x3 gradient magnitude per color channel on a raster pixel stream, with
// mirrored frame borders and results clamped to 255. Results lag the input by one
// row and one pixel; after the last pixel of a frame send image_width+1 drain items
// (mode 1) to flush the rest, the last result carrying frame_end. One item is in
// work at a time: an ignored drain item ends after the decide step, any other item
// that gives no result ends after the window shift, and one that gives a result runs
// the controller sequence (line buffer read, window shift, gradient, square sum)
// and the 8-step square root unit, plus any wait for the output register to
// empty. The line buffers need no clearing after reset. Registers: index 0
// image_width, index 1 image_height; a write restarts the frame.
`include "sobel_rgb_edge_magnitude_defines.svh"

module sobel_rgb_edge_magnitude #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blue_edge,
   output logic [7:0]  rsp_green_edge,
   output logic [7:0]  rsp_red_edge,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   sre_pkg::cmd_type    cmd;
   sre_pkg::status_type status;

   sre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sre_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blue_edge  (rsp_blue_edge),
      .rsp_green_edge (rsp_green_edge),
      .rsp_red_edge   (rsp_red_edge),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   `SRE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `SRE_ASSERT_SAME(a_result_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

>>> design/sre_ram.sv
module sre_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sre_ctrl.sv
module sre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sre_pkg::status_type status,
   output sre_pkg::cmd_type    cmd
);

   sre_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sre_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != sre_pkg::ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         sre_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sre_pkg::ST_DECIDE;
            end
         end
         sre_pkg::ST_DECIDE: begin
            if (status.ignore) begin
               state_in = sre_pkg::ST_IDLE;
            end else if (status.final_px) begin
               cmd.grad_en     = 1'b1;
               cmd.grad_sel    = sre_pkg::GSEL_FINAL;
               cmd.final_clear = 1'b1;
               state_in        = sre_pkg::ST_SQR;
            end else begin
               cmd.read_en  = 1'b1;
               // right-edge result of the row two above uses the window before the shift
               cmd.grad_en  = status.pre;
               cmd.grad_sel = sre_pkg::GSEL_PRE;
               state_in     = sre_pkg::ST_SHIFT;
            end
         end
         sre_pkg::ST_SHIFT: begin
            cmd.shift_en = 1'b1;
            if (status.pre) begin
               state_in = sre_pkg::ST_SQR;
            end else if (status.post) begin
               state_in = sre_pkg::ST_GRAD;
            end else begin
               state_in = sre_pkg::ST_IDLE;
            end
         end
         sre_pkg::ST_GRAD: begin
            cmd.grad_en  = 1'b1;
            cmd.grad_sel = sre_pkg::GSEL_POST;
            state_in     = sre_pkg::ST_SQR;
         end
         sre_pkg::ST_SQR: begin
            cmd.sqr_en = 1'b1;
            state_in   = sre_pkg::ST_SQRT;
         end
         sre_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) begin
               state_in = sre_pkg::ST_OUT;
            end
         end
         sre_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = sre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sre_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/sre_dp.sv
module sre_dp #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  sre_pkg::cmd_type    cmd,
   output sre_pkg::status_type status,
   input  logic                req_mode,
   input  logic [7:0]          req_blue,
   input  logic [7:0]          req_green,
   input  logic [7:0]          req_red,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_blue_edge,
   output logic [7:0]          rsp_green_edge,
   output logic [7:0]          rsp_red_edge,
   output logic                rsp_frame_end,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [11:0]         csr_data
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(MAX_WIDTH);

   logic [10:0] image_width_ff;
   logic [11:0] image_height_ff;
   logic [CW-1:0] eff_w;
   logic [11:0]   eff_h;

   logic [11:0]   in_row_ff;
   logic [CW-1:0] in_col_ff;

   logic          mode_ff;
   logic [23:0]   px_ff;
   logic [11:0]   r_ff;
   logic [CW-1:0] c_ff;
   logic          ign_ff;
   logic          fin_ff;

   logic [23:0] win_ff [3][3];
   logic [23:0] older_rd, newer_rd;

   logic signed [10:0] gx_ff [3];
   logic signed [10:0] gy_ff [3];
   logic signed [10:0] gx_in [3];
   logic signed [10:0] gy_in [3];

   logic [15:0] v_ff   [3];
   logic [15:0] res_ff [3];
   logic        sat_ff [3];
   logic [14:0] bit_ff;
   logic [2:0]  step_ff;

   logic        rsp_valid_ff;
   logic [7:0]  edge_ff [3];
   logic        fe_ff;
   logic        fe_out_ff;

   assign csr_ready = 1'b1;

   // clamp the programmed frame size
   always_comb begin
      if (image_width_ff < 11'd2) begin
         eff_w = CW'(2);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(image_width_ff);
      end
      eff_h = (image_height_ff < 12'd2) ? 12'd2 : image_height_ff;
   end

   // position of the arriving item
   logic          row_full, col_wrap;
   logic [CW-1:0] col_eff;
   always_comb begin
      row_full = (in_row_ff >= eff_h);
      col_wrap = (in_col_ff >= eff_w);
      col_eff  = col_wrap ? '0 : in_col_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         px_ff   <= req_mode ? 24'd0 : {req_red, req_green, req_blue};
         ign_ff  <= req_mode && (in_row_ff != eff_h);
         fin_ff  <= req_mode && (in_row_ff == eff_h) && col_wrap;
         fe_ff   <= req_mode && (in_row_ff == eff_h) && col_wrap;
         if (!req_mode && row_full) begin
            r_ff <= '0;
            c_ff <= '0;
         end else begin
            r_ff <= in_row_ff;
            c_ff <= col_eff;
         end
      end
   end

   always_comb begin
      status.ignore    = ign_ff;
      status.final_px  = fin_ff;
      status.pre       = (c_ff == '0) && (r_ff >= 12'd2);
      status.post      = (c_ff != '0) && (r_ff >= 12'd1);
      status.sqrt_last = (step_ff == sre_pkg::SQRT_LAST);
      status.out_busy  = rsp_valid_ff;
   end

   // configuration and frame counters
   logic [CW-1:0] c_next;
   assign c_next = c_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 11'd640;
         image_height_ff <= 12'd480;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
      end else if (csr_valid && csr_ready &&
                   (csr_index == sre_pkg::CSR_WIDTH || csr_index == sre_pkg::CSR_HEIGHT)) begin
         if (csr_index == sre_pkg::CSR_WIDTH) begin
            image_width_ff <= csr_data[10:0];
         end else begin
            image_height_ff <= csr_data;
         end
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (cmd.final_clear) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (cmd.shift_en) begin
         if (r_ff < eff_h && c_next >= eff_w) begin
            in_row_ff <= r_ff + 12'd1;
            in_col_ff <= '0;
         end else begin
            in_row_ff <= r_ff;
            in_col_ff <= c_next;
         end
      end
   end

   // line buffers
   logic wr_en;
   assign wr_en = cmd.shift_en && !mode_ff;

   sre_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (c_ff[AW-1:0]),
      .wr_data (newer_rd),
      .rd_en   (cmd.read_en),
      .rd_addr (c_ff[AW-1:0]),
      .rd_data (older_rd)
   );

   sre_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (c_ff[AW-1:0]),
      .wr_data (px_ff),
      .rd_en   (cmd.read_en),
      .rd_addr (c_ff[AW-1:0]),
      .rd_data (newer_rd)
   );

   // 3x3 window, rows top..bottom, columns oldest..newest
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (cmd.shift_en) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= older_rd;
         win_ff[1][2] <= newer_rd;
         win_ff[2][2] <= px_ff;
      end
   end

   // gradient with mirrored borders
   always_comb begin
      logic [11:0] rc;
      logic [1:0]  rt, rb, cl, cm, cr;
      logic signed [10:0] tl, tm, tr, ml, mr, bl, bm, br;
      case (cmd.grad_sel)
         sre_pkg::GSEL_PRE: begin
            rc = r_ff - 12'd2;
            cl = 2'd1;
            cm = 2'd2;
            cr = 2'd1;
         end
         sre_pkg::GSEL_POST: begin
            rc = r_ff - 12'd1;
            cl = (c_ff == CW'(1)) ? 2'd2 : 2'd0;
            cm = 2'd1;
            cr = 2'd2;
         end
         sre_pkg::GSEL_FINAL: begin
            rc = eff_h - 12'd1;
            cl = 2'd1;
            cm = 2'd2;
            cr = 2'd1;
         end
         default: begin
            rc = r_ff;
            cl = 2'd0;
            cm = 2'd1;
            cr = 2'd2;
         end
      endcase
      rt = (rc == 12'd0) ? 2'd2 : 2'd0;
      rb = (rc == eff_h - 12'd1) ? 2'd0 : 2'd2;
      for (int ch = 0; ch < 3; ch++) begin
         tl = signed'({3'b000, win_ff[rt][cl][8*ch +: 8]});
         tm = signed'({3'b000, win_ff[rt][cm][8*ch +: 8]});
         tr = signed'({3'b000, win_ff[rt][cr][8*ch +: 8]});
         ml = signed'({3'b000, win_ff[1][cl][8*ch +: 8]});
         mr = signed'({3'b000, win_ff[1][cr][8*ch +: 8]});
         bl = signed'({3'b000, win_ff[rb][cl][8*ch +: 8]});
         bm = signed'({3'b000, win_ff[rb][cm][8*ch +: 8]});
         br = signed'({3'b000, win_ff[rb][cr][8*ch +: 8]});
         gx_in[ch] = (tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl);
         gy_in[ch] = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grad_en) begin
         for (int ch = 0; ch < 3; ch++) begin
            gx_ff[ch] <= gx_in[ch];
            gy_ff[ch] <= gy_in[ch];
         end
      end
   end

   // square sum, then eight restoring root steps per lane
   always_ff @(posedge clock) begin
      logic signed [21:0] sqx, sqy, ssum;
      logic [20:0]        s;
      logic [16:0]        trial;
      if (cmd.sqr_en) begin
         for (int ch = 0; ch < 3; ch++) begin
            sqx = 22'(gx_ff[ch]) * 22'(gx_ff[ch]);
            sqy = 22'(gy_ff[ch]) * 22'(gy_ff[ch]);
            ssum = sqx + sqy;
            s = ssum[20:0];
            sat_ff[ch] <= (s >= sre_pkg::SAT_LIMIT);
            v_ff[ch]   <= s[15:0];
            res_ff[ch] <= '0;
         end
         bit_ff  <= sre_pkg::SQRT_BIT0;
         step_ff <= '0;
      end else if (cmd.sqrt_step) begin
         for (int ch = 0; ch < 3; ch++) begin
            trial = {1'b0, res_ff[ch]} + {2'b00, bit_ff};
            if ({1'b0, v_ff[ch]} >= trial) begin
               v_ff[ch]   <= v_ff[ch] - trial[15:0];
               res_ff[ch] <= (res_ff[ch] >> 1) + {1'b0, bit_ff};
            end else begin
               res_ff[ch] <= res_ff[ch] >> 1;
            end
         end
         bit_ff  <= bit_ff >> 2;
         step_ff <= step_ff + 3'd1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int ch = 0; ch < 3; ch++) begin
            edge_ff[ch] <= sat_ff[ch] ? sre_pkg::EDGE_MAX : res_ff[ch][7:0];
         end
         fe_out_ff <= fe_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue_edge  = edge_ff[0];
   assign rsp_green_edge = edge_ff[1];
   assign rsp_red_edge   = edge_ff[2];
   assign rsp_frame_end  = fe_out_ff;

endmodule
